// ===== rtl/segx_pkg.sv =====
// shared types and constants for the segment intersection pipeline
package segx_pkg;

	// fixed field widths of the transaction payloads
	localparam int COORD_W = 16;
	localparam int OUT_W   = 32;

	// saturation limits of a 32-bit signed coordinate, as magnitudes
	localparam logic [32:0] OUT_POS_LIM = 33'h0_7FFF_FFFF;
	localparam logic [32:0] OUT_NEG_LIM = 33'h0_8000_0000;

	// one input transaction: two segments
	typedef struct packed {
		logic signed [COORD_W-1:0] first_start_x;
		logic signed [COORD_W-1:0] first_start_y;
		logic signed [COORD_W-1:0] first_end_x;
		logic signed [COORD_W-1:0] first_end_y;
		logic signed [COORD_W-1:0] second_start_x;
		logic signed [COORD_W-1:0] second_start_y;
		logic signed [COORD_W-1:0] second_end_x;
		logic signed [COORD_W-1:0] second_end_y;
	} seg_pair_t;

	// one result transaction
	typedef struct packed {
		logic                    hit;
		logic signed [OUT_W-1:0] cross_x;
		logic signed [OUT_W-1:0] cross_y;
	} seg_result_t;

	// per-stage control traveling with the data
	typedef struct packed {
		logic vld;
		logic hit;
	} seg_ctl_t;

endpackage

// ===== rtl/segx_cross.sv =====
// stages 1-4: direction vectors, cross products and the segment hit test
module segx_cross #(
	parameter int COORD_BITS = 16,
	localparam int DW = COORD_BITS + 1,
	localparam int CW = 2 * DW,
	localparam int CM = CW - 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  segx_pkg::seg_pair_t          pair,
	output segx_pkg::seg_ctl_t           ctl,
	output logic signed [COORD_BITS-1:0] ax,
	output logic signed [COORD_BITS-1:0] ay,
	output logic signed [DW-1:0]         rx,
	output logic signed [DW-1:0]         ry,
	output logic [CM-1:0]                c_abs,
	output logic [CM-1:0]                tn_abs
);
	import segx_pkg::*;

	// low coordinate bits, taken as signed
	logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;

	assign a_x = pair.first_start_x[COORD_BITS-1:0];
	assign a_y = pair.first_start_y[COORD_BITS-1:0];
	assign b_x = pair.first_end_x[COORD_BITS-1:0];
	assign b_y = pair.first_end_y[COORD_BITS-1:0];
	assign c_x = pair.second_start_x[COORD_BITS-1:0];
	assign c_y = pair.second_start_y[COORD_BITS-1:0];
	assign d_x = pair.second_end_x[COORD_BITS-1:0];
	assign d_y = pair.second_end_y[COORD_BITS-1:0];

	logic                         vld_s1, vld_s2, vld_s3;
	seg_ctl_t                     ctl_s4;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic signed [DW-1:0]         rx_s1, ry_s1, sx_s1, sy_s1, qx_s1, qy_s1;
	logic signed [DW-1:0]         rx_s2, ry_s2, rx_s3, ry_s3, rx_s4, ry_s4;
	logic signed [CW-1:0]         rxsy_s2, rysx_s2, qxsy_s2, qysx_s2, qxry_s2, qyrx_s2;
	logic signed [CW-1:0]         c_s3, tn_s3, un_s3;
	logic [CM-1:0]                c_abs_s4, tn_abs_s4;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: direction vectors r, s and offset q
	always_ff @(posedge clk) begin
		ax_s1 <= a_x;
		ay_s1 <= a_y;
		rx_s1 <= DW'(b_x) - DW'(a_x);
		ry_s1 <= DW'(b_y) - DW'(a_y);
		sx_s1 <= DW'(d_x) - DW'(c_x);
		sy_s1 <= DW'(d_y) - DW'(c_y);
		qx_s1 <= DW'(c_x) - DW'(a_x);
		qy_s1 <= DW'(c_y) - DW'(a_y);
	end

	// stage 2: the six partial products
	always_ff @(posedge clk) begin
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		rx_s2   <= rx_s1;
		ry_s2   <= ry_s1;
		rxsy_s2 <= CW'(rx_s1) * CW'(sy_s1);
		rysx_s2 <= CW'(ry_s1) * CW'(sx_s1);
		qxsy_s2 <= CW'(qx_s1) * CW'(sy_s1);
		qysx_s2 <= CW'(qy_s1) * CW'(sx_s1);
		qxry_s2 <= CW'(qx_s1) * CW'(ry_s1);
		qyrx_s2 <= CW'(qy_s1) * CW'(rx_s1);
	end

	// stage 3: cross product and the two parameter numerators
	always_ff @(posedge clk) begin
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		rx_s3 <= rx_s2;
		ry_s3 <= ry_s2;
		c_s3  <= rxsy_s2 - rysx_s2;
		tn_s3 <= qxsy_s2 - qysx_s2;
		un_s3 <= qxry_s2 - qyrx_s2;
	end

	// stage 4: range test of t and u against [0,1] by sign and magnitude, plus the magnitudes of c and tn
	logic c_pos, c_nz, in_pos, in_neg, hit_w;

	always_comb begin
		c_pos  = !c_s3[CW-1];
		c_nz   = (c_s3 != CW'(0));
		in_pos = !tn_s3[CW-1] && (tn_s3 <= c_s3) && !un_s3[CW-1] && (un_s3 <= c_s3);
		in_neg = (tn_s3[CW-1] || tn_s3 == CW'(0)) && (tn_s3 >= c_s3)
			&& (un_s3[CW-1] || un_s3 == CW'(0)) && (un_s3 >= c_s3);
		hit_w  = vld_s3 && c_nz && (c_pos ? in_pos : in_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4.vld <= vld_s3;
			ctl_s4.hit <= hit_w;
		end
	end

	always_ff @(posedge clk) begin
		ax_s4     <= ax_s3;
		ay_s4     <= ay_s3;
		rx_s4     <= rx_s3;
		ry_s4     <= ry_s3;
		c_abs_s4  <= c_pos ? CM'(c_s3) : CM'(-c_s3);
		tn_abs_s4 <= c_pos ? CM'(tn_s3) : CM'(-tn_s3);
	end

	assign ctl    = ctl_s4;
	assign ax     = ax_s4;
	assign ay     = ay_s4;
	assign rx     = rx_s4;
	assign ry     = ry_s4;
	assign c_abs  = c_abs_s4;
	assign tn_abs = tn_abs_s4;

	// a hit needs a live item, a nonzero cross product and t within [0,1]
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.hit |-> (ctl_s4.vld && c_abs_s4 != CM'(0) && tn_abs_s4 <= c_abs_s4))
		else $error("hit flagged outside the segment parameter range");

endmodule

// ===== rtl/segx_point.sv =====
// stages 5-7: numerators of the intersection point and their magnitudes
module segx_point #(
	parameter int COORD_BITS = 16,
	localparam int DW = COORD_BITS + 1,
	localparam int CW = 2 * DW,
	localparam int CM = CW - 1,
	localparam int PW = 3 * COORD_BITS + 3,
	localparam int MW = PW - 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  segx_pkg::seg_ctl_t           ctl_in,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [DW-1:0]         rx,
	input  logic signed [DW-1:0]         ry,
	input  logic [CM-1:0]                c_abs,
	input  logic [CM-1:0]                tn_abs,
	output segx_pkg::seg_ctl_t           ctl,
	output logic [CM-1:0]                c_div,
	output logic [MW-1:0]                mag_x,
	output logic [MW-1:0]                mag_y,
	output logic                         neg_x,
	output logic                         neg_y
);
	import segx_pkg::*;

	seg_ctl_t             ctl_s5, ctl_s6, ctl_s7;
	logic signed [CW-1:0] cs, ts;
	logic signed [PW-1:0] pax_s5, pay_s5, ptx_s5, pty_s5, px_s6, py_s6;
	logic [CM-1:0]        c_s5, c_s6, c_s7;
	logic [MW-1:0]        mag_x_s7, mag_y_s7;
	logic                 neg_x_s7, neg_y_s7;

	assign cs = signed'({1'b0, c_abs});
	assign ts = signed'({1'b0, tn_abs});

	// control chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s5 <= ctl_in;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// stage 5: a*c and tn*r for both axes
	always_ff @(posedge clk) begin
		c_s5   <= c_abs;
		pax_s5 <= PW'(ax) * PW'(cs);
		pay_s5 <= PW'(ay) * PW'(cs);
		ptx_s5 <= PW'(ts) * PW'(rx);
		pty_s5 <= PW'(ts) * PW'(ry);
	end

	// stage 6: point numerators a*c + tn*r
	always_ff @(posedge clk) begin
		c_s6  <= c_s5;
		px_s6 <= pax_s5 + ptx_s5;
		py_s6 <= pay_s5 + pty_s5;
	end

	// stage 7: sign and magnitude for the divider
	always_ff @(posedge clk) begin
		c_s7     <= c_s6;
		neg_x_s7 <= px_s6[PW-1];
		neg_y_s7 <= py_s6[PW-1];
		mag_x_s7 <= px_s6[PW-1] ? MW'(-px_s6) : MW'(px_s6);
		mag_y_s7 <= py_s6[PW-1] ? MW'(-py_s6) : MW'(py_s6);
	end

	assign ctl   = ctl_s7;
	assign c_div = c_s7;
	assign mag_x = mag_x_s7;
	assign mag_y = mag_y_s7;
	assign neg_x = neg_x_s7;
	assign neg_y = neg_y_s7;

endmodule

// ===== rtl/segx_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with rounding and saturation
module segx_div #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16,
	localparam int CM = 2 * COORD_BITS + 3,
	localparam int MW = 3 * COORD_BITS + 2,
	localparam int QW = COORD_BITS + FRAC_BITS + 1,
	localparam int SW = (QW > 32) ? QW : 33
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  segx_pkg::seg_ctl_t      ctl_in,
	input  logic [CM-3:0]           c_div,
	input  logic [MW-1:0]           mag_x,
	input  logic [MW-1:0]           mag_y,
	input  logic                    neg_x,
	input  logic                    neg_y,
	output logic                    done,
	output segx_pkg::seg_result_t   result
);
	import segx_pkg::*;

	// divisor width; remainders stay below the divisor
	localparam int DVW = CM - 2;

	// round half away from zero on the magnitude, saturate, then apply the sign
	function automatic logic [OUT_W-1:0] to_fixed(input logic [QW-1:0] q, input logic neg);
		logic [QW:0]   rnd;
		logic [SW-1:0] mag;
		logic [SW-1:0] lim;
		rnd = (QW+1)'(q) + (QW+1)'(1);
		mag = SW'(rnd[QW:1]);
		lim = neg ? SW'(OUT_NEG_LIM) : SW'(OUT_POS_LIM);
		if (mag > lim) begin
			mag = lim;
		end
		return neg ? OUT_W'(-mag) : OUT_W'(mag);
	endfunction

	// stage registers of the divider
	seg_ctl_t         ctl_s [0:QW-1];
	logic [DVW-1:0]   dvs_s [0:QW-1];
	logic [DVW-1:0]   remx_s [0:QW-1];
	logic [DVW-1:0]   remy_s [0:QW-1];
	logic [QW-1:0]    qdx_s [0:QW-1];
	logic [QW-1:0]    qdy_s [0:QW-1];
	logic             ngx_s [0:QW-1];
	logic             ngy_s [0:QW-1];

	// initial remainder is the integer part above the quotient window
	logic [DVW-1:0] rem0_x, rem0_y;
	logic [QW-1:0]  qd0_x, qd0_y;

	assign rem0_x = DVW'(mag_x[MW-1:COORD_BITS]);
	assign rem0_y = DVW'(mag_y[MW-1:COORD_BITS]);
	assign qd0_x  = {mag_x[COORD_BITS-1:0], {(FRAC_BITS+1){1'b0}}};
	assign qd0_y  = {mag_y[COORD_BITS-1:0], {(FRAC_BITS+1){1'b0}}};

	for (genvar k = 0; k < QW; k++) begin : g_step
		seg_ctl_t       ctl_p;
		logic [DVW-1:0] dvs_p, rem_x_p, rem_y_p;
		logic [QW-1:0]  qd_x_p, qd_y_p;
		logic           ngx_p, ngy_p;
		logic [DVW:0]   tx, ty;
		logic           gex, gey;

		if (k == 0) begin : g_head
			assign ctl_p   = ctl_in;
			assign dvs_p   = c_div;
			assign rem_x_p = rem0_x;
			assign rem_y_p = rem0_y;
			assign qd_x_p  = qd0_x;
			assign qd_y_p  = qd0_y;
			assign ngx_p   = neg_x;
			assign ngy_p   = neg_y;
		end else begin : g_link
			assign ctl_p   = ctl_s[k-1];
			assign dvs_p   = dvs_s[k-1];
			assign rem_x_p = remx_s[k-1];
			assign rem_y_p = remy_s[k-1];
			assign qd_x_p  = qdx_s[k-1];
			assign qd_y_p  = qdy_s[k-1];
			assign ngx_p   = ngx_s[k-1];
			assign ngy_p   = ngy_s[k-1];
		end

		// bring down the next dividend bit and try the subtract
		assign tx  = {rem_x_p, qd_x_p[QW-1]};
		assign ty  = {rem_y_p, qd_y_p[QW-1]};
		assign gex = (tx >= {1'b0, dvs_p});
		assign gey = (ty >= {1'b0, dvs_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			dvs_s[k]  <= dvs_p;
			remx_s[k] <= gex ? DVW'(tx - {1'b0, dvs_p}) : DVW'(tx);
			remy_s[k] <= gey ? DVW'(ty - {1'b0, dvs_p}) : DVW'(ty);
			qdx_s[k]  <= {qd_x_p[QW-2:0], gex};
			qdy_s[k]  <= {qd_y_p[QW-2:0], gey};
			ngx_s[k]  <= ngx_p;
			ngy_s[k]  <= ngy_p;
		end
	end

	// output register
	logic        done_q;
	seg_result_t result_q;
	seg_result_t result_n;

	always_comb begin
		result_n.hit     = ctl_s[QW-1].hit;
		result_n.cross_x = ctl_s[QW-1].hit ? to_fixed(qdx_s[QW-1], ngx_s[QW-1]) : '0;
		result_n.cross_y = ctl_s[QW-1].hit ? to_fixed(qdy_s[QW-1], ngy_s[QW-1]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[QW-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_n;
	end

	assign done   = done_q;
	assign result = result_q;

	// on a hit the point lies on the segment, so the quotient fits and remainders stay bounded
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[QW-1].hit |-> (remx_s[QW-1] < dvs_s[QW-1] && remy_s[QW-1] < dvs_s[QW-1]))
		else $error("divider remainder not below divisor on a hit");

endmodule

// ===== rtl/segment_intersection_2d.sv =====
// top level of the 2-d segment intersection pipeline
//
// Usage: drive pair with two segments and raise start for one cycle per
// transaction. busy is held low: a new transaction is accepted on every
// clock edge at which start is high, back to back without gaps.
// Each transaction produces exactly one result. done is high for one
// cycle while result carries hit and the intersection point cross_x,
// cross_y with FRAC_BITS fraction bits (both zero when there is no hit).
// Pipeline: four stages for the cross products and hit test, three for
// the point numerators, one restoring divider stage per quotient bit
// (COORD_BITS + FRAC_BITS + 1 of them) and one output register; the
// first stage loads at the accepting edge itself.
// Throughput: one transaction per cycle, results in input order.
// Reset: arst_n clears all valid bits; transactions in flight are dropped
// and no done pulse appears until new work arrives.
// The receiver cannot stall; each result is presented for one cycle only.
module segment_intersection_2d #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  segx_pkg::seg_pair_t   pair,
	output logic                  done,
	output segx_pkg::seg_result_t result
);
	import segx_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int CM = 2 * DW - 1;
	localparam int MW = 3 * COORD_BITS + 2;

	seg_ctl_t                     ctl_cr, ctl_pt;
	logic signed [COORD_BITS-1:0] ax, ay;
	logic signed [DW-1:0]         rx, ry;
	logic [CM-1:0]                c_abs, tn_abs, c_div;
	logic [MW-1:0]                mag_x, mag_y;
	logic                         neg_x, neg_y;

	// fully pipelined, never refuses a transaction
	assign busy = 1'b0;

	// cross products and hit test
	segx_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.pair   (pair),
		.ctl    (ctl_cr),
		.ax     (ax),
		.ay     (ay),
		.rx     (rx),
		.ry     (ry),
		.c_abs  (c_abs),
		.tn_abs (tn_abs)
	);

	// point numerators
	segx_point #(
		.COORD_BITS(COORD_BITS)
	) u_point (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_cr),
		.ax     (ax),
		.ay     (ay),
		.rx     (rx),
		.ry     (ry),
		.c_abs  (c_abs),
		.tn_abs (tn_abs),
		.ctl    (ctl_pt),
		.c_div  (c_div),
		.mag_x  (mag_x),
		.mag_y  (mag_y),
		.neg_x  (neg_x),
		.neg_y  (neg_y)
	);

	// fixed-point division and output register
	segx_div #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_pt),
		.c_div  (c_div),
		.mag_x  (mag_x),
		.mag_y  (mag_y),
		.neg_x  (neg_x),
		.neg_y  (neg_y),
		.done   (done),
		.result (result)
	);

	// a transaction without a hit reports the origin
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.cross_x == '0 && result.cross_y == '0))
		else $error("nonzero point reported without a hit");

endmodule
